// ----- sv/min_tracking_stack_assert.svh -----
// ----------------------------------------------------------------------------
// min tracking stack assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// clocked property with active-low reset disable
`define MTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same property, checked on the cycle after the antecedent
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and codes of the min tracking stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request action codes, the unused code acts as a query
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic                     is_full;
    status_e                  status;
  } rsp_t;

  // one stack entry: value and minimum of the stack up to it
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] min_val;
  } entry_t;

  // shift command broadcast to the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ----- sv/mts_cell.sv -----
// ----------------------------------------------------------------------------
// mts_cell
// one stack slot, shifts down on push and up on pop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_cell (
  input  logic            clk_i,
  input  mts_pkg::shift_t cmd_i,
  input  mts_pkg::entry_t above_i,
  input  mts_pkg::entry_t below_i,
  output mts_pkg::entry_t entry_o
);

  mts_pkg::entry_t entry_q;

  // take the neighbor toward the top on push, toward the bottom on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      entry_q <= above_i;
    end else if (cmd_i.pop) begin
      entry_q <= below_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- sv/mts_ctrl.sv -----
// ----------------------------------------------------------------------------
// mts_ctrl
// request decode, fill level, capacity register and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  mts_pkg::req_t              req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output mts_pkg::rsp_t              rsp_o,
  input  logic                       cfg_we_i,
  input  logic [mts_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  mts_pkg::entry_t            top_i,
  input  mts_pkg::entry_t            next_i,
  output mts_pkg::shift_t            cmd_o,
  output mts_pkg::entry_t            push_entry_o
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > mts_pkg::CAP_W) ? LW : mts_pkg::CAP_W;

  logic [mts_pkg::CAP_W-1:0] cap_q;
  logic [LW-1:0]             level_q, level_d;
  logic                      rsp_valid_q, rsp_valid_d;
  mts_pkg::rsp_t             rsp_q, rsp_d;

  logic [CW-1:0]             cap_ext, eff_cap;
  logic                      full_now, empty_now, accept;
  logic                      do_push, do_pop;
  mts_pkg::status_e          status;
  logic signed [mts_pkg::DATA_W-1:0] new_min;

  // capacity clamped to one .. DEPTH
  always_comb begin
    cap_ext = CW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full_now  = CW'(level_q) >= eff_cap;
  assign empty_now = (level_q == '0);

  // one request in flight at the response register
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // action decode
  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    status  = mts_pkg::ST_OK;
    unique case (req_i.action)
      mts_pkg::ACT_PUSH: begin
        if (full_now) begin
          status = mts_pkg::ST_OVERFLOW;
        end else begin
          do_push = accept;
        end
      end
      mts_pkg::ACT_POP: begin
        if (empty_now) begin
          status = mts_pkg::ST_UNDERFLOW;
        end else begin
          do_pop = accept;
        end
      end
      default: begin
        status = mts_pkg::ST_OK;
      end
    endcase
  end

  // running minimum for the new top entry
  always_comb begin
    if (!empty_now && !($signed(req_i.push_value) < $signed(top_i.min_val))) begin
      new_min = top_i.min_val;
    end else begin
      new_min = req_i.push_value;
    end
  end

  assign push_entry_o.value   = req_i.push_value;
  assign push_entry_o.min_val = new_min;
  assign cmd_o.push           = do_push;
  assign cmd_o.pop            = do_pop;

  // next fill level
  always_comb begin
    level_d = level_q;
    if (do_push) begin
      level_d = level_q + LW'(1);
    end else if (do_pop) begin
      level_d = level_q - LW'(1);
    end
  end

  // response as it stands after the operation
  always_comb begin
    rsp_d.popped_value = do_pop ? top_i.value : '0;
    rsp_d.status       = status;
    rsp_d.is_empty     = (level_d == '0);
    rsp_d.is_full      = CW'(level_d) >= eff_cap;
    if (do_push) begin
      rsp_d.top_value = req_i.push_value;
      rsp_d.min_value = new_min;
    end else if (do_pop) begin
      if (level_d == '0) begin
        rsp_d.top_value = '0;
        rsp_d.min_value = '0;
      end else begin
        rsp_d.top_value = next_i.value;
        rsp_d.min_value = next_i.min_val;
      end
    end else if (empty_now) begin
      rsp_d.top_value = '0;
      rsp_d.min_value = '0;
    end else begin
      rsp_d.top_value = top_i.value;
      rsp_d.min_value = top_i.min_val;
    end
  end

  // response valid handshake
  always_comb begin
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= mts_pkg::CAP_RESET;
      level_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      level_q     <= level_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- sv/min_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack
// response: registered in the response register when the request is taken
// throughput: one request per cycle unless a held response stalls, every push or pop shifts the whole
//   cell chain by one slot with the top at cell zero
// reset: level and response valid clear, capacity returns to 64,
//   cell contents stay undefined and need no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  mts_pkg::req_t             req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output mts_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [mts_pkg::CAP_W-1:0] cfg_wdata_i
);

  mts_pkg::entry_t cell_entry [DEPTH];
  mts_pkg::entry_t push_entry;
  mts_pkg::shift_t cmd;

  // control and response path
  mts_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_i        (req_i),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_ready_i  (rsp_ready_i),
    .rsp_o        (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .top_i        (cell_entry[0]),
    .next_i       (cell_entry[1]),
    .cmd_o        (cmd),
    .push_entry_o (push_entry)
  );

  // chain of cells, cell zero holds the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mts_pkg::entry_t above, below;

    if (i == 0) begin : g_first
      assign above = push_entry;
    end else begin : g_mid_above
      assign above = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = cell_entry[i];
    end else begin : g_mid_below
      assign below = cell_entry[i+1];
    end

    mts_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_entry[i])
    );
  end

endmodule

// ----- sv/mts_checker.sv -----
// ----------------------------------------------------------------------------
// mts_checker
// port level checks of the min tracking stack responses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "min_tracking_stack_assert.svh"

module mts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input mts_pkg::rsp_t rsp_o
);

  // stalled response holds
  `MTS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o), "stalled response changed")

  // capacity is at least one, so a full stack is never empty
  `MTS_ASSERT(a_full_not_empty, clk_i, rst_ni, rsp_valid_o |-> !(rsp_o.is_empty && rsp_o.is_full), "response both empty and full")

  // empty stack reads zero top and minimum
  `MTS_ASSERT(a_empty_zero, clk_i, rst_ni, (rsp_valid_o && rsp_o.is_empty) |-> (rsp_o.top_value == '0 && rsp_o.min_value == '0), "empty stack with nonzero top or min")

  // underflow leaves the stack empty and pops nothing
  `MTS_ASSERT(a_underflow, clk_i, rst_ni, (rsp_valid_o && rsp_o.status == mts_pkg::ST_UNDERFLOW) |-> (rsp_o.is_empty && rsp_o.popped_value == '0), "bad underflow response")

  // overflow only on a full stack
  `MTS_ASSERT(a_overflow, clk_i, rst_ni, (rsp_valid_o && rsp_o.status == mts_pkg::ST_OVERFLOW) |-> (rsp_o.is_full && rsp_o.popped_value == '0), "overflow on a stack that is not full")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

// ----- tb/min_tracking_stack_test.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack_test
// self-checking bench for the min tracking stack: a directed table covers
// empty, full, extreme values, the spare action code and capacity corners,
// then random push/pop/query phases run under several capacities with
// random request gaps and response stalls, each response checked against
// an internal model of the stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_test;

  localparam int DATA_W          = mts_pkg::DATA_W;
  localparam int CAP_W           = mts_pkg::CAP_W;
  localparam int STACK_DEPTH     = 64;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 8;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TIMEOUT_NS      = 5_000_000;

  // unused action code, behaves as a query
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum logic {
    ROW_REQUEST,
    ROW_CAPACITY
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic [CAP_W-1:0]         capacity;
    logic                     typed;
    mts_pkg::rsp_t            want;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             req_valid_i;
  logic             req_ready_o;
  mts_pkg::req_t    req_i;
  logic             rsp_valid_o;
  logic             rsp_ready_i;
  mts_pkg::rsp_t    rsp_o;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  // model state of the stack
  logic signed [DATA_W-1:0] stack_value [STACK_DEPTH];
  logic signed [DATA_W-1:0] stack_min   [STACK_DEPTH];
  int unsigned              fill_level;
  logic [CAP_W-1:0]         capacity_reg;

  mts_pkg::rsp_t pending_stack_rsp [$];
  stim_row_t     directed_rows [$];
  mts_pkg::rsp_t oldest_rsp;
  int unsigned   mismatch_count;
  bit            gaps_on;
  bit            rsp_stall_on;
  int unsigned   stall_left;

  min_tracking_stack #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one request to the model and return the response it produces
  function automatic mts_pkg::rsp_t apply_stack_op(input mts_pkg::req_t r);
    mts_pkg::rsp_t            res;
    int unsigned              limit;
    logic signed [DATA_W-1:0] run_min;
    res        = '0;
    res.status = mts_pkg::ST_OK;
    limit = (capacity_reg == '0) ? 1 :
            ((int'(capacity_reg) > STACK_DEPTH) ? STACK_DEPTH : int'(capacity_reg));
    case (r.action)
      mts_pkg::ACT_PUSH: begin
        if (fill_level >= limit) begin
          res.status = mts_pkg::ST_OVERFLOW;
        end else begin
          run_min = r.push_value;
          if (fill_level > 0 && stack_min[fill_level-1] < run_min) begin
            run_min = stack_min[fill_level-1];
          end
          stack_value[fill_level] = r.push_value;
          stack_min[fill_level]   = run_min;
          fill_level++;
        end
      end
      mts_pkg::ACT_POP: begin
        if (fill_level == 0) begin
          res.status = mts_pkg::ST_UNDERFLOW;
        end else begin
          fill_level--;
          res.popped_value = stack_value[fill_level];
        end
      end
      default: ;
    endcase
    if (fill_level > 0) begin
      res.top_value = stack_value[fill_level-1];
      res.min_value = stack_min[fill_level-1];
    end
    res.is_empty = (fill_level == 0);
    res.is_full  = (fill_level >= limit);
    return res;
  endfunction

  function automatic mts_pkg::rsp_t make_rsp(input logic signed [DATA_W-1:0] popped,
                                             input logic signed [DATA_W-1:0] top,
                                             input logic signed [DATA_W-1:0] minv,
                                             input logic empty, input logic full,
                                             input mts_pkg::status_e st);
    mts_pkg::rsp_t res;
    res.popped_value = popped;
    res.top_value    = top;
    res.min_value    = minv;
    res.is_empty     = empty;
    res.is_full      = full;
    res.status       = st;
    return res;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [1:0] act,
                                  input logic signed [DATA_W-1:0] val,
                                  input logic [CAP_W-1:0] cap,
                                  input logic typed, input mts_pkg::rsp_t want);
    stim_row_t row;
    row.kind     = kind;
    row.action   = act;
    row.value    = val;
    row.capacity = cap;
    row.typed    = typed;
    row.want     = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // drive one request, return at the edge where it is taken
  task automatic send_request(input logic [1:0] act, input logic signed [DATA_W-1:0] val,
                              input logic typed, input mts_pkg::rsp_t want);
    mts_pkg::req_t r;
    mts_pkg::rsp_t predicted;
    int unsigned   gap;
    r.action     = act;
    r.push_value = val;
    gap = (gaps_on && $urandom_range(0, 99) < 35) ? idle_length() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    predicted = apply_stack_op(r);
    pending_stack_rsp.push_back(typed ? want : predicted);
  endtask

  // hold off requests until every response is back
  task automatic drain_pause();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (pending_stack_rsp.size() != 0) @(negedge clk_i);
  endtask

  // capacity write, only with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    capacity_reg = cap;
  endtask

  // response side: random stalls while enabled
  initial begin
    rsp_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ready_i <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready_i <= 1'b1;
        if (rsp_stall_on && $urandom_range(0, 99) < 25) stall_left = idle_length();
      end
    end
  end

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_stack_rsp.size() == 0) begin
        $error("response with no request pending");
        mismatch_count++;
      end else begin
        oldest_rsp = pending_stack_rsp.pop_front();
        check_field("popped_value", oldest_rsp.popped_value, rsp_o.popped_value);
        check_field("top_value", oldest_rsp.top_value, rsp_o.top_value);
        check_field("min_value", oldest_rsp.min_value, rsp_o.min_value);
        check_field("is_empty", DATA_W'(oldest_rsp.is_empty), DATA_W'(rsp_o.is_empty));
        check_field("is_full", DATA_W'(oldest_rsp.is_full), DATA_W'(rsp_o.is_full));
        check_field("status", DATA_W'(oldest_rsp.status), DATA_W'(rsp_o.status));
      end
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    int                       cap_plan  [NUM_PHASES];
    int                       push_plan [NUM_PHASES];
    int unsigned              roll;
    logic [1:0]               act;
    logic signed [DATA_W-1:0] val;
    stim_row_t                row;

    rst_ni         = 1'b0;
    req_valid_i    = 1'b0;
    req_i          = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    fill_level     = 0;
    capacity_reg   = mts_pkg::CAP_RESET;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    rsp_stall_on   = 1'b1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty stack right after reset
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b1,
            make_rsp(0, 0, 0, 1'b1, 1'b0, mts_pkg::ST_UNDERFLOW));
    add_row(ROW_REQUEST, mts_pkg::ACT_QUERY, VAL_MAX, '0, 1'b1,
            make_rsp(0, 0, 0, 1'b1, 1'b0, mts_pkg::ST_OK));
    // extremes, minimum follows the smallest entry
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, VAL_MAX, '0, 1'b1,
            make_rsp(0, VAL_MAX, VAL_MAX, 1'b0, 1'b0, mts_pkg::ST_OK));
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, VAL_MIN, '0, 1'b1,
            make_rsp(0, VAL_MIN, VAL_MIN, 1'b0, 1'b0, mts_pkg::ST_OK));
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, 32'sd5, '0, 1'b1,
            make_rsp(0, 32'sd5, VAL_MIN, 1'b0, 1'b0, mts_pkg::ST_OK));
    add_row(ROW_REQUEST, ACT_SPARE, -32'sd1, '0, 1'b1,
            make_rsp(0, 32'sd5, VAL_MIN, 1'b0, 1'b0, mts_pkg::ST_OK));
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b1,
            make_rsp(32'sd5, VAL_MIN, VAL_MIN, 1'b0, 1'b0, mts_pkg::ST_OK));
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b1,
            make_rsp(VAL_MIN, VAL_MAX, VAL_MAX, 1'b0, 1'b0, mts_pkg::ST_OK));
    // equal values and ties on the minimum
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, VAL_MAX, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, -32'sd1, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, -32'sd1, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b0, '0);
    // capacity dropped below the current level
    add_row(ROW_CAPACITY, mts_pkg::ACT_QUERY, 32'sd0, 7'd2, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_QUERY, 32'sd0, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, 32'sd7, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b0, '0);
    // zero capacity acts as one
    add_row(ROW_CAPACITY, mts_pkg::ACT_QUERY, 32'sd0, 7'd0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, 32'sd0, '0, 1'b1,
            make_rsp(0, 0, 0, 1'b0, 1'b1, mts_pkg::ST_OK));
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, 32'sd1, '0, 1'b1,
            make_rsp(0, 0, 0, 1'b0, 1'b1, mts_pkg::ST_OVERFLOW));
    add_row(ROW_REQUEST, mts_pkg::ACT_POP, 32'sd0, '0, 1'b1,
            make_rsp(0, 0, 0, 1'b1, 1'b0, mts_pkg::ST_OK));
    // capacity above depth acts as depth
    add_row(ROW_CAPACITY, mts_pkg::ACT_QUERY, 32'sd0, 7'd127, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_PUSH, VAL_MIN, '0, 1'b0, '0);
    add_row(ROW_REQUEST, mts_pkg::ACT_QUERY, 32'sd0, '0, 1'b0, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CAPACITY) write_capacity(row.capacity);
      else send_request(row.action, row.value, row.typed, row.want);
    end

    // random phases, fill-heavy and drain-heavy mixes under several capacities
    cap_plan  = '{64, 5, 127, 0, $urandom_range(1, 64), 1, $urandom_range(2, 16), 127};
    push_plan = '{70, 55, 80, 30, 50, 60, 60, 40};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(CAP_W'(cap_plan[ph]));
      gaps_on      = (ph % 3) != 2;
      rsp_stall_on = gaps_on;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_plan[ph]) act = mts_pkg::ACT_PUSH;
        else if (roll < push_plan[ph] + 4) act = ACT_SPARE;
        else if (roll < push_plan[ph] + 14) act = mts_pkg::ACT_QUERY;
        else act = mts_pkg::ACT_POP;
        // small values give ties, a few extremes, the rest full range
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          val = $urandom_range(0, 8);
          val = val - 4;
        end else if (roll < 35) begin
          case ($urandom_range(0, 3))
            0: val = VAL_MIN;
            1: val = VAL_MAX;
            2: val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end else begin
          val = $urandom;
        end
        if ($urandom_range(0, 199) == 0) drain_pause();
        send_request(act, val, 1'b0, '0);
      end
    end

    // wind down
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (pending_stack_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
